FILE: rtl/pmcrt_pkg.sv
package pmcrt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int IF_W = 32;
  localparam int STATUS_W = 3;

  localparam logic [IF_W-1:0] NOT_GIVEN = '1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADARG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DEL    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IF_W-1:0] ingress_if;
    logic [IF_W-1:0] egress_if;
    logic [IF_W-1:0] context_if;
  } item_t;

  typedef struct packed {
    logic [IF_W-1:0]     rx_if_out;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic                egress_attached;
    logic [IF_W-1:0]     rewrite_count;
    logic [IF_W-1:0]     pass_count;
  } result_t;

  // What travels down the row of cells, gathering what each slot knows.
  typedef struct packed {
    logic            valid;
    op_t             op;
    logic [IF_W-1:0] ingress_if;
    logic [IF_W-1:0] egress_if;
    logic [IF_W-1:0] context_if;
    logic [IF_W-1:0] rx;
    logic            hit;
    logic            egr_used;
    logic            egr_other;
    logic            free_found;
  } token_t;

  typedef struct packed {
    logic            en;
    logic [IF_W-1:0] ingress_if;
    logic [IF_W-1:0] egress_if;
    logic [IF_W-1:0] context_if;
  } slot_wr_t;

endpackage

FILE: rtl/pmcrt_cell.sv
module pmcrt_cell
  import pmcrt_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  token_t           tok_in,
  input  logic [IDX_W-1:0] idx_in,
  output token_t           tok_out,
  output logic [IDX_W-1:0] idx_out,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] wr_idx
);

  localparam logic [IDX_W-1:0] OWN_IDX = IDX_W'(INDEX);

  logic            valid;
  logic [IF_W-1:0] slot_ing;
  logic [IF_W-1:0] slot_egr;
  logic [IF_W-1:0] slot_ctx;

  logic             match_pair;
  logic             match_egr;
  logic             del_hit;
  logic             wr_here;
  token_t           tok_next;
  logic [IDX_W-1:0] idx_next;

  assign match_egr  = valid && (slot_egr == tok_in.egress_if);
  assign match_pair = match_egr && (slot_ing == tok_in.ingress_if);
  assign del_hit    = tok_in.valid && (tok_in.op == OP_DEL) && match_pair &&
                      (tok_in.ingress_if != NOT_GIVEN) && (tok_in.egress_if != NOT_GIVEN);
  assign wr_here    = wr.en && (wr_idx == OWN_IDX);

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    if (match_pair) begin
      tok_next.hit = 1'b1;
      tok_next.rx  = slot_ctx;
    end
    if (match_egr) begin
      tok_next.egr_used = 1'b1;
    end
    if (match_egr && !match_pair) begin
      tok_next.egr_other = 1'b1;
    end
    if (!valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      idx_next            = OWN_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.valid && (tok_in.op == OP_CLEAR)) begin
        valid <= 1'b0;
      end else if (del_hit) begin
        valid <= 1'b0;
      end else if (wr_here) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_out <= idx_next;
    if (wr_here) begin
      slot_ing <= wr.ingress_if;
      slot_egr <= wr.egress_if;
      slot_ctx <= wr.context_if;
    end
  end

endmodule

FILE: rtl/pair_match_context_rewrite_table.sv
// Each beat walks the row of slot cells, one cell per cycle; at the end of the row
// it is held in pend, and its result then goes to the output register.
// One beat is in flight at a time; a new beat is taken once the previous
// result has moved into the output register.
// Synchronous reset empties the table, zeroes both counters and drops any beat.
module pair_match_context_rewrite_table
  import pmcrt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t           state;
  token_t           head;
  token_t           pend;
  logic [IDX_W-1:0] pend_idx;
  logic [IF_W-1:0]  rewritten_total;
  logic [IF_W-1:0]  passed_total;

  token_t           chain_tok [0:TABLE_DEPTH];
  logic [IDX_W-1:0] chain_idx [0:TABLE_DEPTH];

  logic             accept;
  logic             finish;
  slot_wr_t         wr;
  result_t          res_next;
  token_t           head_next;
  logic [IF_W-1:0]  rewritten_next;
  logic [IF_W-1:0]  passed_next;

  assign item_stall   = (state != S_IDLE);
  assign accept       = item_valid && !item_stall;
  assign finish       = (state == S_FINISH) && (!result_valid || !result_stall);
  assign chain_tok[0] = head;
  assign chain_idx[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    pmcrt_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain_tok[g]),
      .idx_in  (chain_idx[g]),
      .tok_out (chain_tok[g+1]),
      .idx_out (chain_idx[g+1]),
      .wr      (wr),
      .wr_idx  (pend_idx)
    );
  end

  always_comb begin
    head_next            = '0;
    head_next.valid      = accept;
    head_next.op         = item.op;
    head_next.ingress_if = item.ingress_if;
    head_next.egress_if  = item.egress_if;
    head_next.context_if = item.context_if;
  end

  always_comb begin
    res_next       = '0;
    rewritten_next = rewritten_total;
    passed_next    = passed_total;
    wr.en          = 1'b0;
    wr.ingress_if  = pend.ingress_if;
    wr.egress_if   = pend.egress_if;
    wr.context_if  = pend.context_if;
    res_next.status          = ST_OK;
    res_next.egress_attached = pend.egr_used;
    case (pend.op)
      OP_LOOKUP: begin
        res_next.hit = pend.hit;
        if (pend.hit) begin
          res_next.rx_if_out = pend.rx;
          rewritten_next     = rewritten_total + 1'b1;
        end else begin
          res_next.rx_if_out = pend.ingress_if;
          if (pend.egr_used) begin
            passed_next = passed_total + 1'b1;
          end
        end
      end
      OP_ADD: begin
        if ((pend.ingress_if == NOT_GIVEN) || (pend.egress_if == NOT_GIVEN) ||
            (pend.context_if == NOT_GIVEN)) begin
          res_next.status = ST_BADARG;
        end else if (pend.hit) begin
          res_next.status = ST_DUP;
        end else if (!pend.free_found) begin
          res_next.status = ST_FULL;
        end else begin
          wr.en                    = finish;
          res_next.egress_attached = 1'b1;
        end
      end
      OP_DEL: begin
        if ((pend.ingress_if == NOT_GIVEN) || (pend.egress_if == NOT_GIVEN)) begin
          res_next.status = ST_BADARG;
        end else if (!pend.hit) begin
          res_next.status = ST_NOTFOUND;
        end else begin
          res_next.egress_attached = pend.egr_other;
        end
      end
      OP_CLEAR: begin
        res_next.egress_attached = 1'b0;
      end
      default: begin
        res_next.status = ST_OK;
      end
    endcase
    res_next.rewrite_count = rewritten_next;
    res_next.pass_count    = passed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      head            <= '0;
      pend            <= '0;
      pend_idx        <= '0;
      rewritten_total <= '0;
      passed_total    <= '0;
      result_valid    <= 1'b0;
      result          <= '0;
    end else begin
      head         <= head_next;
      result_valid <= finish || (result_valid && result_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (chain_tok[TABLE_DEPTH].valid) begin
            pend     <= chain_tok[TABLE_DEPTH];
            pend_idx <= chain_idx[TABLE_DEPTH];
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            result          <= res_next;
            rewritten_total <= rewritten_next;
            passed_total    <= passed_next;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/tb_pair_match_context_rewrite_table.sv
`timescale 1ns / 1ps

module tb_pair_match_context_rewrite_table;
  import pmcrt_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int QUIET_LIMIT = 4000;
  localparam int POOL_MAX = 7;

  typedef struct {
    item_t   beat;
    bit      typed;
    result_t want;
  } row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Shadow copy of the rewrite table and its counters.
  bit              pair_used [DEPTH];
  logic [IF_W-1:0] pair_ing  [DEPTH];
  logic [IF_W-1:0] pair_egr  [DEPTH];
  logic [IF_W-1:0] pair_ctx  [DEPTH];
  logic [IF_W-1:0] rewrites = '0;
  logic [IF_W-1:0] passes = '0;

  result_t expected_q[$];
  row_t    directed_rows[$];
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles = 0;
  bit      failed = 1'b0;

  pair_match_context_rewrite_table dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_pair(logic [IF_W-1:0] ing, logic [IF_W-1:0] egr);
    for (int k = 0; k < DEPTH; k++) begin
      if (pair_used[k] && pair_ing[k] == ing && pair_egr[k] == egr) return k;
    end
    return -1;
  endfunction

  function automatic bit egress_in_use(logic [IF_W-1:0] egr);
    for (int k = 0; k < DEPTH; k++) begin
      if (pair_used[k] && pair_egr[k] == egr) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_table_op(item_t it);
    result_t r;
    int idx;
    r = '0;
    r.status = ST_OK;
    case (it.op)
      OP_LOOKUP: begin
        idx = find_pair(it.ingress_if, it.egress_if);
        if (idx >= 0) begin
          r.rx_if_out = pair_ctx[idx];
          r.hit = 1'b1;
          rewrites = rewrites + 1;
        end else begin
          r.rx_if_out = it.ingress_if;
          if (egress_in_use(it.egress_if)) passes = passes + 1;
        end
      end
      OP_ADD: begin
        if (it.ingress_if == NOT_GIVEN || it.egress_if == NOT_GIVEN ||
            it.context_if == NOT_GIVEN) begin
          r.status = ST_BADARG;
        end else if (find_pair(it.ingress_if, it.egress_if) >= 0) begin
          r.status = ST_DUP;
        end else begin
          idx = -1;
          for (int k = 0; k < DEPTH; k++) begin
            if (!pair_used[k]) begin
              idx = k;
              break;
            end
          end
          if (idx < 0) begin
            r.status = ST_FULL;
          end else begin
            pair_used[idx] = 1'b1;
            pair_ing[idx] = it.ingress_if;
            pair_egr[idx] = it.egress_if;
            pair_ctx[idx] = it.context_if;
          end
        end
      end
      OP_DEL: begin
        if (it.ingress_if == NOT_GIVEN || it.egress_if == NOT_GIVEN) begin
          r.status = ST_BADARG;
        end else begin
          idx = find_pair(it.ingress_if, it.egress_if);
          if (idx < 0) r.status = ST_NOTFOUND;
          else pair_used[idx] = 1'b0;
        end
      end
      default: begin
        for (int k = 0; k < DEPTH; k++) pair_used[k] = 1'b0;
      end
    endcase
    r.egress_attached = (it.op == OP_CLEAR) ? 1'b0 : egress_in_use(it.egress_if);
    r.rewrite_count = rewrites;
    r.pass_count = passes;
    return r;
  endfunction

  function automatic item_t make_item(op_t op, logic [IF_W-1:0] ing, logic [IF_W-1:0] egr,
                                      logic [IF_W-1:0] ctx);
    item_t it;
    it.op = op;
    it.ingress_if = ing;
    it.egress_if = egr;
    it.context_if = ctx;
    return it;
  endfunction

  function automatic result_t make_result(logic [IF_W-1:0] rx, logic hit,
                                          logic [STATUS_W-1:0] st, logic att,
                                          logic [IF_W-1:0] rw, logic [IF_W-1:0] pc);
    result_t r;
    r.rx_if_out = rx;
    r.hit = hit;
    r.status = st;
    r.egress_attached = att;
    r.rewrite_count = rw;
    r.pass_count = pc;
    return r;
  endfunction

  task automatic add_row(item_t it, bit typed = 1'b0, result_t want = '0);
    row_t row;
    row.beat = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Mostly a small pool so that pairs collide, with some extremes and noise.
  function automatic logic [IF_W-1:0] pick_if();
    int sel;
    sel = $urandom_range(99);
    if (sel < 62) return IF_W'($urandom_range(POOL_MAX));
    if (sel < 70) return NOT_GIVEN;
    if (sel < 73) return NOT_GIVEN - 1;
    if (sel < 76) return '0;
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(item_t it, bit typed = 1'b0, result_t want = '0);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item = it;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = predict_table_op(it);
    expected_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic fill_table();
    send_beat(make_item(OP_CLEAR, $urandom, $urandom, $urandom));
    for (int k = 0; k < DEPTH; k++) begin
      send_beat(make_item(OP_ADD, IF_W'(k % 8), IF_W'(k / 8), $urandom));
    end
    send_beat(make_item(OP_ADD, 32'd8, 32'd8, $urandom));
    send_beat(make_item(OP_ADD, 32'd3, 32'd5, $urandom));
    send_beat(make_item(OP_ADD, NOT_GIVEN, 32'd9, $urandom));
  endtask

  task automatic check_field(string name, logic [IF_W-1:0] want, logic [IF_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(negedge clk) begin
    result_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending: 0x%0h", result);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        check_field("rx_if_out", want.rx_if_out, result.rx_if_out);
        check_field("hit", IF_W'(want.hit), IF_W'(result.hit));
        check_field("status", IF_W'(want.status), IF_W'(result.status));
        check_field("egress_attached", IF_W'(want.egress_attached),
                    IF_W'(result.egress_attached));
        check_field("rewrite_count", want.rewrite_count, result.rewrite_count);
        check_field("pass_count", want.pass_count, result.pass_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_pair_match_context_rewrite_table: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_modes[4][2];
    int sel;
    op_t op;
    idle_modes = '{'{0, 0}, '{83, 0}, '{0, 83}, '{8, 8}};

    add_row(make_item(OP_LOOKUP, 32'd0, 32'd0, 32'd0), 1'b1,
            make_result(32'd0, 1'b0, ST_OK, 1'b0, 32'd0, 32'd0));
    add_row(make_item(OP_LOOKUP, NOT_GIVEN, NOT_GIVEN, NOT_GIVEN), 1'b1,
            make_result(NOT_GIVEN, 1'b0, ST_OK, 1'b0, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, NOT_GIVEN, 32'd1, 32'd5), 1'b1,
            make_result(32'd0, 1'b0, ST_BADARG, 1'b0, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, 32'd1, NOT_GIVEN, 32'd5), 1'b1,
            make_result(32'd0, 1'b0, ST_BADARG, 1'b0, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, 32'd1, 32'd2, NOT_GIVEN), 1'b1,
            make_result(32'd0, 1'b0, ST_BADARG, 1'b0, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, 32'd1, 32'd2, 32'h55), 1'b1,
            make_result(32'd0, 1'b0, ST_OK, 1'b1, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, 32'd1, 32'd2, 32'h66), 1'b1,
            make_result(32'd0, 1'b0, ST_DUP, 1'b1, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, 32'd0, 32'd0, 32'd0));
    add_row(make_item(OP_ADD, NOT_GIVEN - 1, NOT_GIVEN - 1, NOT_GIVEN - 1));
    add_row(make_item(OP_LOOKUP, 32'd1, 32'd2, NOT_GIVEN));
    add_row(make_item(OP_LOOKUP, 32'd3, 32'd2, 32'd0));
    add_row(make_item(OP_LOOKUP, 32'd3, 32'd9, 32'd0));
    add_row(make_item(OP_LOOKUP, NOT_GIVEN - 1, NOT_GIVEN - 1, 32'd0));
    add_row(make_item(OP_LOOKUP, 32'd0, 32'd0, 32'hA5A5_5A5A));
    add_row(make_item(OP_DEL, NOT_GIVEN, 32'd2, 32'd0));
    add_row(make_item(OP_DEL, 32'd1, NOT_GIVEN, 32'd0));
    add_row(make_item(OP_DEL, 32'd5, 32'd2, 32'd0));
    add_row(make_item(OP_DEL, 32'd1, 32'd2, 32'd0));
    add_row(make_item(OP_LOOKUP, 32'd1, 32'd2, 32'd0));
    add_row(make_item(OP_ADD, 32'd4, 32'd0, 32'hFFFF_0000));
    add_row(make_item(OP_LOOKUP, 32'd7, 32'd0, 32'd0));
    add_row(make_item(OP_CLEAR, NOT_GIVEN, NOT_GIVEN, NOT_GIVEN));
    add_row(make_item(OP_LOOKUP, 32'd0, 32'd0, 32'd0));
    add_row(make_item(OP_DEL, 32'd0, 32'd0, 32'd0));

    for (int k = 0; k < DEPTH; k++) pair_used[k] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_modes[ph][0];
      stall_pct = idle_modes[ph][1];
      fill_table();
      for (int n = 0; n < 330; n++) begin
        sel = $urandom_range(99);
        if (sel < 45) op = OP_LOOKUP;
        else if (sel < 75) op = OP_ADD;
        else if (sel < 98) op = OP_DEL;
        else op = OP_CLEAR;
        send_beat(make_item(op, pick_if(), pick_if(),
                            ($urandom_range(9) == 0) ? NOT_GIVEN : $urandom));
      end
    end

    item_valid = 1'b0;
    stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (!failed) begin
      $display("tb_pair_match_context_rewrite_table: clean");
    end else begin
      $display("tb_pair_match_context_rewrite_table: errors");
    end
    $finish;
  end

endmodule
